[hdl/wgc_pkg.sv]
// Shared types, constants and tables for the go-to-goal controller.
package wgc_pkg;

	localparam int NUM_GOALS    = 4;
	localparam int CORDIC_STEPS = 16;
	localparam int CW           = 34;
	localparam int MUL_W        = 21;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int ROOT_W       = 17;
	localparam int RAD_W        = 34;
	localparam int DIFF_W       = 20;

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	localparam logic [30:0] ATAN_Q30 [CORDIC_STEPS] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
		31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
		31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
		31'd262144,    31'd131072,    31'd65536,     31'd32768
	};

	localparam logic [31:0] GOAL_RESET [NUM_GOALS] = '{
		32'd268447744, 32'd1342185472, 32'd536911872, 32'd1476417536
	};
	localparam logic [2:0]  GOAL_COUNT_RESET = 3'd4;
	localparam logic [15:0] TOLERANCE_RESET  = 16'd410;
	localparam logic [15:0] GAIN_LIN_RESET   = 16'd6144;
	localparam logic [15:0] GAIN_ANG_RESET   = 16'd24576;

	localparam logic signed [PROD_W-1:0] LIN_MAX = PROD_W'(262143);
	localparam logic signed [PROD_W-1:0] ANG_MAX = PROD_W'(262143);
	localparam logic signed [PROD_W-1:0] ANG_MIN = -PROD_W'(262144);

	localparam logic OP_POSE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		REG_GOAL_0,
		REG_GOAL_1,
		REG_GOAL_2,
		REG_GOAL_3,
		REG_GOAL_COUNT,
		REG_TOLERANCE,
		REG_GAIN_LIN,
		REG_GAIN_ANG
	} wgc_reg_t;

	typedef struct packed {
		logic load;
		logic step;
	} wgc_iter_ctl_t;

endpackage

[hdl/wgc_mul.sv]
// Shared signed multiplier with registered product.
module wgc_mul (
	input  logic                                 clk,
	input  logic signed [wgc_pkg::MUL_W-1:0]     a,
	input  logic signed [wgc_pkg::MUL_W-1:0]     b,
	output logic signed [wgc_pkg::PROD_W-1:0]    p_q
);
	import wgc_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

[hdl/wgc_isqrt.sv]
// Bitwise restoring integer square root, one result bit per step.
module wgc_isqrt (
	input  logic                                clk,
	input  wgc_pkg::wgc_iter_ctl_t              ctl,
	input  logic [wgc_pkg::RAD_W-1:0]           radicand,
	output logic [wgc_pkg::ROOT_W-1:0]          root_q
);
	import wgc_pkg::*;

	logic [RAD_W-1:0] rad_q;
	logic [20:0]      rem_q;
	logic [20:0]      rem_sh;
	logic [20:0]      trial;
	logic             ge;

	assign rem_sh = {rem_q[18:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctl.step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule

[hdl/wgc_cordic.sv]
// Iterative CORDIC vectoring unit giving the bearing of an offset vector.
module wgc_cordic #(
	parameter int FRAC_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wgc_pkg::wgc_iter_ctl_t                ctl,
	input  logic signed [16:0]                    dx,
	input  logic signed [16:0]                    dy,
	output logic signed [wgc_pkg::DIFF_W-1:0]     bearing
);
	import wgc_pkg::*;

	localparam int                    SH  = 30 - FRAC_BITS;
	localparam logic signed [CW-1:0]  RND = CW'(64'sd1 <<< (29 - FRAC_BITS));
	localparam logic signed [CW-1:0]  HALF_PI = CW'(HALF_PI_Q30);

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [3:0]           i_q;
	logic signed [16:0]   x0, y0;
	logic signed [CW-1:0] z0;
	logic signed [CW-1:0] xs, ys, at;
	logic signed [CW-1:0] bsum, bshift;

	always_comb begin
		if (dx < 0) begin
			if (dy >= 0) begin
				x0 = dy;
				y0 = -dx;
				z0 = HALF_PI;
			end else begin
				x0 = -dy;
				y0 = dx;
				z0 = -HALF_PI;
			end
		end else begin
			x0 = dx;
			y0 = dy;
			z0 = '0;
		end
	end

	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign at     = $signed({3'b000, ATAN_Q30[i_q]});
	assign bsum   = z_q + RND;
	assign bshift = bsum >>> SH;
	assign bearing = bshift[DIFF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (ctl.load) begin
			i_q <= '0;
		end else if (ctl.step) begin
			i_q <= i_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= {{3{x0[16]}}, x0, 14'd0};
			y_q <= {{3{y0[16]}}, y0, 14'd0};
			z_q <= z0;
		end else if (ctl.step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

endmodule

[hdl/waypoint_go_to_goal_controller_top.sv]
// Go-to-goal controller top: configuration, sequencer and result register.
// A pose update, or a tick with no pose or no goal left, stays in S_IDLE. A
// goal-reached tick runs S_SQX, S_SQY, S_TOL, S_CMP, then S_OUT raises its result; a
// motion tick adds S_ITER, S_WRAP (at most one two-pi wrap), S_LIN, S_ANG and S_SAT.
// Input is ready again as the result is raised, later while a previous result waits.
// The 17-step root outlasts the 16-step CORDIC in S_ITER. Reset restores defaults.
module waypoint_go_to_goal_controller_top #(
	parameter int MAX_GOALS = 4,
	parameter int FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [15:0]        pose_x,
	input  logic [15:0]        pose_y,
	input  logic signed [14:0] pose_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [17:0]        linear_speed,
	output logic signed [18:0] angular_speed,
	output logic               goal_reached,
	output logic [1:0]         goal_index
);
	import wgc_pkg::*;

	localparam longint                PI_L  = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS)))
		>>> (30 - FRAC_BITS);
	localparam logic signed [DIFF_W-1:0] PI_Q     = DIFF_W'(PI_L);
	localparam logic signed [DIFF_W-1:0] TWO_PI_Q = DIFF_W'(2 * PI_L);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_TOL,
		S_CMP,
		S_ITER,
		S_WRAP,
		S_LIN,
		S_ANG,
		S_SAT,
		S_OUT
	} state_t;

	state_t state_q;

	logic [31:0] goal_q [NUM_GOALS];
	logic [2:0]  goal_count_q;
	logic [15:0] tolerance_q, gain_lin_q, gain_ang_q;

	logic [15:0]               stored_x_q, stored_y_q;
	logic signed [14:0]        stored_heading_q;
	logic [2:0]                next_goal_q;

	logic signed [16:0]        dx_q, dy_q;
	logic [RAD_W-1:0]          acc_q;
	logic [1:0]                gi_q;
	logic [4:0]                cnt_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic [17:0]               lin_q;
	logic signed [18:0]        ang_q;
	logic                      reached_q;

	logic                      out_valid_q;
	logic [17:0]               lin_out_q;
	logic signed [18:0]        ang_out_q;
	logic                      reached_out_q;
	logic [1:0]                gi_out_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_q, prod_sh;
	logic [ROOT_W-1:0]         root;
	logic signed [DIFF_W-1:0]  bearing;
	wgc_iter_ctl_t             sqrt_ctl, cordic_ctl;

	logic [2:0]                count_eff;
	logic [31:0]               goal_sel;
	logic                      far;

	assign count_eff = (goal_count_q > 3'(MAX_GOALS)) ? 3'(MAX_GOALS) : goal_count_q;
	assign goal_sel  = goal_q[next_goal_q[1:0]];
	assign far       = acc_q > prod_q[RAD_W-1:0];
	assign prod_sh   = prod_q >>> FRAC_BITS;

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign linear_speed  = lin_out_q;
	assign angular_speed = ang_out_q;
	assign goal_reached  = reached_out_q;
	assign goal_index    = gi_out_q;

	always_comb begin
		case (state_q)
			S_SQX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			S_SQY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			S_TOL: begin
				mul_a = $signed({5'd0, tolerance_q});
				mul_b = $signed({5'd0, tolerance_q});
			end
			S_LIN: begin
				mul_a = $signed({5'd0, gain_lin_q});
				mul_b = $signed({4'd0, root});
			end
			S_ANG: begin
				mul_a = $signed({5'd0, gain_ang_q});
				mul_b = MUL_W'(diff_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign sqrt_ctl.load   = (state_q == S_CMP) && far;
	assign sqrt_ctl.step   = (state_q == S_ITER);
	assign cordic_ctl.load = (state_q == S_CMP) && far;
	assign cordic_ctl.step = (state_q == S_ITER) && !cnt_q[4];

	wgc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	wgc_isqrt u_isqrt (
		.clk      (clk),
		.ctl      (sqrt_ctl),
		.radicand (acc_q),
		.root_q   (root)
	);

	wgc_cordic #(
		.FRAC_BITS (FRAC_BITS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cordic_ctl),
		.dx      (dx_q),
		.dy      (dy_q),
		.bearing (bearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_GOALS; k++) begin
				goal_q[k] <= GOAL_RESET[k];
			end
			goal_count_q <= GOAL_COUNT_RESET;
			tolerance_q  <= TOLERANCE_RESET;
			gain_lin_q   <= GAIN_LIN_RESET;
			gain_ang_q   <= GAIN_ANG_RESET;
		end else if (cfg_we) begin
			case (wgc_reg_t'(cfg_index))
				REG_GOAL_0, REG_GOAL_1, REG_GOAL_2, REG_GOAL_3: begin
					if (int'(cfg_index) < MAX_GOALS) begin
						goal_q[cfg_index[1:0]] <= cfg_wdata;
					end
				end
				REG_GOAL_COUNT: goal_count_q <= cfg_wdata[2:0];
				REG_TOLERANCE:  tolerance_q  <= cfg_wdata[15:0];
				REG_GAIN_LIN:   gain_lin_q   <= cfg_wdata[15:0];
				REG_GAIN_ANG:   gain_ang_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			stored_x_q       <= '0;
			stored_y_q       <= '0;
			stored_heading_q <= '0;
			next_goal_q      <= '0;
			cnt_q            <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (opcode == OP_POSE) begin
							stored_x_q       <= pose_x;
							stored_y_q       <= pose_y;
							stored_heading_q <= pose_heading;
						end else if (!(stored_x_q == '0 && stored_y_q == '0) &&
							(next_goal_q < count_eff)) begin
							dx_q    <= $signed({1'b0, goal_sel[31:16]})
								- $signed({1'b0, stored_x_q});
							dy_q    <= $signed({1'b0, goal_sel[15:0]})
								- $signed({1'b0, stored_y_q});
							gi_q    <= next_goal_q[1:0];
							state_q <= S_SQX;
						end
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					acc_q   <= prod_q[RAD_W-1:0];
					state_q <= S_TOL;
				end
				S_TOL: begin
					acc_q   <= acc_q + prod_q[RAD_W-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (far) begin
						cnt_q   <= '0;
						state_q <= S_ITER;
					end else begin
						lin_q       <= '0;
						ang_q       <= '0;
						reached_q   <= 1'b1;
						next_goal_q <= next_goal_q + 3'd1;
						state_q     <= S_OUT;
					end
				end
				S_ITER: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(CORDIC_STEPS)) begin
						diff_q  <= bearing - DIFF_W'(stored_heading_q);
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (diff_q > PI_Q) begin
						diff_q <= diff_q - TWO_PI_Q;
					end else if (diff_q < -PI_Q) begin
						diff_q <= diff_q + TWO_PI_Q;
					end else begin
						state_q <= S_LIN;
					end
				end
				S_LIN: state_q <= S_ANG;
				S_ANG: begin
					lin_q   <= (prod_sh > LIN_MAX) ? 18'h3FFFF : prod_sh[17:0];
					state_q <= S_SAT;
				end
				S_SAT: begin
					if (prod_sh > ANG_MAX) begin
						ang_q <= ANG_MAX[18:0];
					end else if (prod_sh < ANG_MIN) begin
						ang_q <= ANG_MIN[18:0];
					end else begin
						ang_q <= prod_sh[18:0];
					end
					reached_q <= 1'b0;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						lin_out_q     <= lin_q;
						ang_out_q     <= ang_q;
						reached_out_q <= reached_q;
						gi_out_q      <= gi_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_reached_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && goal_reached) |-> (linear_speed == '0 && angular_speed == '0))
		else $error("goal-reached item carries nonzero speed");

	a_goal_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(next_goal_q != $past(next_goal_q)) |-> ($past(state_q) == S_CMP && reached_q))
		else $error("goal index advanced outside a goal-reached decision");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result item raised outside the output step");

	a_wrap_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIN) |-> (diff_q <= PI_Q && diff_q >= -PI_Q))
		else $error("heading error left outside [-pi, pi]");

endmodule
